### hw/rtl/frqg_pkg.sv
// Shared types and constants for the frame rate quality governor.
// Used by frqg_ctrl, frqg_dp and frame_rate_quality_governor; no dependencies.
package frqg_pkg;

   // History ring geometry and datapath widths.
   localparam int HIST_DEPTH = 128;
   localparam int HIST_AW    = 7;
   localparam int FILL_W     = 8;
   localparam int SUM_W      = 21;
   localparam int DIV_STEPS  = SUM_W;
   localparam int DCNT_W     = 5;

   // Field widths.
   localparam int RATE_W  = 14;
   localparam int TIME_W  = 20;
   localparam int TIMER_W = 24;
   localparam int LVL_W   = 3;
   localparam int CNT_W   = 32;
   localparam int REQ_DW  = 40;
   localparam int RSP_DW  = 56;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 24;

   // Hold times loaded after a level step, in microseconds.
   localparam logic [TIMER_W-1:0] DOWN_HOLD = 24'd2000000;
   localparam logic [TIMER_W-1:0] UP_HOLD   = 24'd5000000;

   localparam logic [LVL_W-1:0] MAX_LEVEL = 3'd4;

   // Evaluation windows and minimum fill.
   localparam logic [FILL_W-1:0] MIN_FILL  = 8'd10;
   localparam logic [FILL_W-1:0] LOW_WIN   = 8'd30;
   localparam logic [FILL_W-1:0] HIGH_WIN  = 8'd60;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_ENABLE   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_TARGET   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_HYST     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_EMERG    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_INTERVAL = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_LOWEST   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_HIGHEST  = 3'd6;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_WALK   = 5'b00010,
      S_DIV    = 5'b00100,
      S_DECIDE = 5'b01000,
      S_OUT    = 5'b10000
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;
      logic walk;
      logic div_load;
      logic div_step;
      logic decide;
      logic load_rsp;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic frame_go;
      logic walk_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/frqg_ctrl.sv
// Sequencing state machine of the frame rate quality governor.
// Depends on frqg_pkg; drives commands into frqg_dp.
module frqg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  frqg_pkg::status_type status,
   output frqg_pkg::cmd_type    cmd
);
   import frqg_pkg::*;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.frame_go ? S_WALK : S_OUT;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/frqg_dp.sv
// Datapath of the frame rate quality governor: configuration, history memory,
// history walk, mean divider, level decision and result register. Uses frqg_pkg.
module frqg_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  frqg_pkg::cmd_type            cmd,
   output frqg_pkg::status_type         status,
   input  logic [frqg_pkg::REQ_DW-1:0]  req_tdata,
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [frqg_pkg::RSP_DW-1:0]  rsp_tdata,
   input  logic                         csr_we,
   input  logic [frqg_pkg::CSR_AW-1:0]  csr_index,
   input  logic [frqg_pkg::CSR_DW-1:0]  csr_wdata
);
   import frqg_pkg::*;

   // Configuration registers.
   logic               enable_ff;
   logic [RATE_W-1:0]  target_ff, hyst_ff, emerg_ff;
   logic [TIMER_W-1:0] interval_ff;
   logic [LVL_W-1:0]   lowest_ff, highest_ff;

   // Governor state.
   logic [RATE_W-1:0]  mem [HIST_DEPTH];
   logic [HIST_AW-1:0] wi_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [TIMER_W-1:0] timer_ff, uhold_ff, dhold_ff;
   logic [LVL_W-1:0]   level_ff, prior_ff;
   logic [RATE_W-1:0]  mean_ff, rate_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               changed_ff, eval_ff;

   // Walk and divider state.
   logic [FILL_W-1:0]  issue_ff, rd_k_ff;
   logic               rd_pend_ff;
   logic [RATE_W-1:0]  rd_data_ff;
   logic [SUM_W-1:0]   acc_ff, quo_ff;
   logic [4:0]         hits_lo_ff;
   logic [5:0]         hits_hi_ff;
   logic [FILL_W-1:0]  rem_ff;
   logic [DCNT_W-1:0]  dcnt_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [RSP_DW-1:0]  rsp_data_ff;

   // Input fields.
   logic [TIME_W-1:0]  in_dt;
   logic [RATE_W-1:0]  in_rate;
   logic [LVL_W-1:0]   in_rlvl;

   assign in_dt   = req_tdata[19:0];
   assign in_rate = req_tdata[33:20];
   assign in_rlvl = req_tdata[36:34];

   // Capped level bounds and thresholds.
   logic [LVL_W-1:0]         lo_cap, hi_cap, rst_lvl;
   logic signed [RATE_W:0]   lo_thr;
   logic [RATE_W:0]          hi_thr;
   logic [RATE_W+1:0]        up2;

   assign lo_cap = (lowest_ff  > MAX_LEVEL) ? MAX_LEVEL : lowest_ff;
   assign hi_cap = (highest_ff > MAX_LEVEL) ? MAX_LEVEL : highest_ff;
   assign lo_thr = $signed({1'b0, target_ff}) - $signed({1'b0, hyst_ff});
   assign hi_thr = {1'b0, target_ff} + {1'b0, hyst_ff};
   assign up2    = {1'b0, target_ff, 1'b0} + {2'b00, hyst_ff};

   // Reset command clamps the requested level: lower bound first, then upper.
   always_comb begin
      rst_lvl = in_rlvl;
      if (rst_lvl < lo_cap) rst_lvl = lo_cap;
      if (rst_lvl > hi_cap) rst_lvl = hi_cap;
   end

   // Timer and hold updates for an accepted frame.
   logic [TIMER_W:0]   t_sum;
   logic [TIMER_W-1:0] t_sat, uh_dec, dh_dec;

   assign t_sum  = {1'b0, timer_ff} + (TIMER_W+1)'(in_dt);
   assign t_sat  = t_sum[TIMER_W] ? {TIMER_W{1'b1}} : t_sum[TIMER_W-1:0];
   assign uh_dec = (uhold_ff > TIMER_W'(in_dt)) ? uhold_ff - TIMER_W'(in_dt) : '0;
   assign dh_dec = (dhold_ff > TIMER_W'(in_dt)) ? dhold_ff - TIMER_W'(in_dt) : '0;

   assign status.frame_go  = !req_tuser && enable_ff && (in_dt != '0);
   assign status.walk_done = (issue_ff == fill_ff) && !rd_pend_ff;
   assign status.div_done  = (dcnt_ff == DCNT_W'(DIV_STEPS));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         target_ff   <= 14'd960;
         hyst_ff     <= 14'd80;
         emerg_ff    <= 14'd480;
         interval_ff <= 24'd1000000;
         lowest_ff   <= 3'd0;
         highest_ff  <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_TARGET:   target_ff   <= csr_wdata[RATE_W-1:0];
            CSR_HYST:     hyst_ff     <= csr_wdata[RATE_W-1:0];
            CSR_EMERG:    emerg_ff    <= csr_wdata[RATE_W-1:0];
            CSR_INTERVAL: interval_ff <= csr_wdata;
            CSR_LOWEST:   lowest_ff   <= csr_wdata[LVL_W-1:0];
            CSR_HIGHEST:  highest_ff  <= csr_wdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   // History memory: one write at capture, one registered read per walk cycle.
   logic [HIST_AW-1:0] rd_addr;

   assign rd_addr = wi_ff - HIST_AW'(1) - issue_ff[HIST_AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture && status.frame_go) begin
         mem[wi_ff] <= in_rate;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Level decision after the walk: regular evaluation, then emergency step.
   logic signed [23:0] lo_prod, sum_s;
   logic [22:0]        hi_prod;
   logic [FILL_W-1:0]  cnt_lo, cnt_hi;
   logic               ev, low_mean, high_mean, down_ok, up_ok;
   logic [LVL_W-1:0]   lvl_in;
   logic [TIMER_W-1:0] uh_in, dh_in;
   logic [1:0]         steps_in;

   assign lo_prod   = 24'(lo_thr) * $signed({16'd0, fill_ff});
   assign sum_s     = $signed({3'd0, acc_ff});
   assign hi_prod   = 23'(hi_thr) * 23'(fill_ff);
   assign cnt_lo    = (fill_ff < LOW_WIN)  ? fill_ff : LOW_WIN;
   assign cnt_hi    = (fill_ff < HIGH_WIN) ? fill_ff : HIGH_WIN;
   assign ev        = eval_ff && (fill_ff >= MIN_FILL);
   assign low_mean  = sum_s < lo_prod;
   assign high_mean = {2'b00, acc_ff} > hi_prod;
   assign down_ok   = (10'(hits_lo_ff) * 10'd10) > (10'(cnt_lo) * 10'd6);
   assign up_ok     = (10'(hits_hi_ff) * 10'd10) > (10'(cnt_hi) * 10'd8);

   always_comb begin
      lvl_in   = level_ff;
      uh_in    = uhold_ff;
      dh_in    = dhold_ff;
      steps_in = 2'd0;
      if (ev && low_mean && (dhold_ff == '0)) begin
         if ((level_ff > lo_cap) && down_ok) begin
            lvl_in   = level_ff - LVL_W'(1);
            dh_in    = DOWN_HOLD;
            uh_in    = UP_HOLD;
            steps_in = 2'd1;
         end
      end else if (ev && high_mean && (uhold_ff == '0)) begin
         if ((level_ff < hi_cap) && up_ok) begin
            lvl_in   = level_ff + LVL_W'(1);
            uh_in    = UP_HOLD;
            steps_in = 2'd1;
         end
      end
      // A single rate below the emergency threshold steps down at once.
      if ((rate_ff < emerg_ff) && (dh_in == '0) && (lvl_in > lo_cap)) begin
         lvl_in   = lvl_in - LVL_W'(1);
         dh_in    = DOWN_HOLD;
         uh_in    = UP_HOLD;
         steps_in = steps_in + 2'd1;
      end
   end

   // Governor state, walk and divider.
   logic [FILL_W:0] div_sh;

   assign div_sh = {rem_ff, quo_ff[SUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff      <= '0;
         fill_ff    <= '0;
         timer_ff   <= '0;
         uhold_ff   <= '0;
         dhold_ff   <= '0;
         level_ff   <= MAX_LEVEL;
         mean_ff    <= 14'd960;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         issue_ff   <= '0;
         dcnt_ff    <= '0;
      end else begin
         if (cmd.capture) begin
            prior_ff   <= level_ff;
            rate_ff    <= in_rate;
            changed_ff <= req_tuser && (rst_lvl != level_ff);
            issue_ff   <= '0;
            rd_pend_ff <= 1'b0;
            acc_ff     <= '0;
            hits_lo_ff <= '0;
            hits_hi_ff <= '0;
            if (req_tuser) begin
               if (rst_lvl != level_ff) begin
                  level_ff   <= rst_lvl;
                  count_ff   <= count_ff + CNT_W'(1);
               end
               wi_ff    <= '0;
               fill_ff  <= '0;
               timer_ff <= '0;
               uhold_ff <= '0;
               dhold_ff <= '0;
            end else if (status.frame_go) begin
               wi_ff <= wi_ff + HIST_AW'(1);
               if (fill_ff < FILL_W'(HIST_DEPTH)) fill_ff <= fill_ff + FILL_W'(1);
               uhold_ff <= uh_dec;
               dhold_ff <= dh_dec;
               eval_ff  <= (t_sat >= interval_ff);
               timer_ff <= (t_sat >= interval_ff) ? '0 : t_sat;
            end
         end
         // Walk from the newest entry back over the filled part.
         if (cmd.walk) begin
            if (issue_ff < fill_ff) begin
               rd_pend_ff <= 1'b1;
               rd_k_ff    <= issue_ff;
               issue_ff   <= issue_ff + FILL_W'(1);
            end else begin
               rd_pend_ff <= 1'b0;
            end
            if (rd_pend_ff) begin
               acc_ff <= acc_ff + SUM_W'(rd_data_ff);
               if ((rd_k_ff < LOW_WIN) && ($signed({1'b0, rd_data_ff}) < lo_thr)) begin
                  hits_lo_ff <= hits_lo_ff + 5'd1;
               end
               if ((rd_k_ff < HIGH_WIN) && ({1'b0, rd_data_ff, 1'b0} > up2)) begin
                  hits_hi_ff <= hits_hi_ff + 6'd1;
               end
            end
         end
         // Restoring divider for the mean, one quotient bit per cycle.
         if (cmd.div_load) begin
            quo_ff  <= acc_ff;
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end else if (cmd.div_step) begin
            if (div_sh >= {1'b0, fill_ff}) begin
               rem_ff <= FILL_W'(div_sh - {1'b0, fill_ff});
               quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= div_sh[FILL_W-1:0];
               quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
         end
         if (cmd.decide) begin
            mean_ff    <= quo_ff[RATE_W-1:0];
            level_ff   <= lvl_in;
            uhold_ff   <= uh_in;
            dhold_ff   <= dh_in;
            count_ff   <= count_ff + CNT_W'(steps_in);
            changed_ff <= (steps_in != 2'd0);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {3'b000, count_ff, mean_ff, changed_ff, prior_ff, level_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/frame_rate_quality_governor.sv
// Frame rate quality governor top level: controller plus datapath.
// Depends on frqg_pkg, frqg_ctrl and frqg_dp.
//
// Usage: one req beat per rendered frame. tuser selects the kind (0 frame
// sample, 1 reset to reset_level); tdata carries frame time, frame rate and
// reset level. Every req beat yields exactly one rsp beat with the new and
// prior quality level, a changed flag, the history mean and the running
// count of level changes. The csr port writes the seven settings by index.
// Sequence: for a reset command, a disabled block or a zero frame time the
// controller goes from idle straight to the output state, which loads the rsp
// register once it is free. A recorded frame passes the walk state, which
// reads the history memory once per stored sample (at most 128), the bit-serial
// mean divider (21 steps and a done check), the decision state and the output
// state, which loads the rsp register.
// One beat is in work at a time; req_tready is high while idle, even when a
// finished result still waits in the rsp register. A stalled rsp side holds
// the result and keeps the next item from completing.
// Reset loads the default settings, level 4, mean 960 and an empty history;
// no memory clearing pass is needed.
module frame_rate_quality_governor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // frame_time_us[19:0], frame_rate[33:20], reset_level[36:34], zero fill
   input  logic [frqg_pkg::REQ_DW-1:0]  req_tdata,
   // command
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // level[2:0], prior_level[5:3], changed[6], mean_rate[20:7],
   // adjustment_count[52:21], zero fill
   output logic [frqg_pkg::RSP_DW-1:0]  rsp_tdata,
   input  logic                         csr_we,
   input  logic [frqg_pkg::CSR_AW-1:0]  csr_index,
   input  logic [frqg_pkg::CSR_DW-1:0]  csr_wdata
);
   import frqg_pkg::*;

   cmd_type    cmd;
   status_type status;

   frqg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   frqg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

`ifndef NO_ASSERTIONS
   // The reported level never exceeds the top quality level.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= MAX_LEVEL))
      else $error("reported level out of range");

   // An unchanged result keeps the prior level.
   a_unchanged: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[6]) |-> (rsp_tdata[2:0] == rsp_tdata[5:3]))
      else $error("level moved without changed flag");

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat accepted while busy");
`endif

endmodule

### tb/frame_rate_quality_governor_checker.sv
// Checker for the frame rate quality governor: predicts every result beat from
// the accepted request beats and compares it field by field.
// Depends on frqg_pkg; watches the ports of frame_rate_quality_governor.
`timescale 1ns / 1ps

module frame_rate_quality_governor_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [frqg_pkg::REQ_DW-1:0]   req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [frqg_pkg::RSP_DW-1:0]   rsp_tdata,
   input  logic                          csr_we,
   input  logic [frqg_pkg::CSR_AW-1:0]   csr_index,
   input  logic [frqg_pkg::CSR_DW-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   import frqg_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]  adjustment_count;
      logic [RATE_W-1:0] mean_rate;
      logic              changed;
      logic [LVL_W-1:0]  prior_level;
      logic [LVL_W-1:0]  level;
   } governor_result_type;

   // Shadow settings.
   logic               gov_enable;
   logic [RATE_W-1:0]  gov_target, gov_hyst, gov_emerg;
   logic [TIMER_W-1:0] gov_interval;
   logic [LVL_W-1:0]   gov_lowest, gov_highest;

   // Shadow state.
   logic [RATE_W-1:0]  rate_ring [HIST_DEPTH];
   int unsigned        ring_wr, ring_fill;
   longint unsigned    eval_timer, up_hold, down_hold;
   logic [LVL_W-1:0]   cur_level;
   logic [RATE_W-1:0]  stored_mean;
   logic [CNT_W-1:0]   level_changes;
   bit                 stepped;

   governor_result_type expected_results[$];

   function automatic int unsigned cap_level(logic [LVL_W-1:0] v);
      return (v > MAX_LEVEL) ? 4 : v;
   endfunction

   function automatic void step_to(int unsigned lv);
      if (lv != cur_level) begin
         cur_level = LVL_W'(lv);
         level_changes = level_changes + 1;
         stepped = 1;
      end
   endfunction

   function automatic logic [RATE_W-1:0] recent_rate(int unsigned back);
      return rate_ring[(ring_wr + 2 * HIST_DEPTH - 1 - back) % HIST_DEPTH];
   endfunction

   // Periodic evaluation on the mean and the recent samples.
   function automatic void evaluate_level(longint sum);
      longint n, lo_thr, hi_thr, up2;
      int unsigned lo, hi, cnt, hits;
      n = ring_fill;
      lo_thr = longint'(gov_target) - longint'(gov_hyst);
      hi_thr = longint'(gov_target) + longint'(gov_hyst);
      up2 = 2 * longint'(gov_target) + longint'(gov_hyst);
      lo = cap_level(gov_lowest);
      hi = cap_level(gov_highest);
      if (ring_fill < 10) return;
      if (sum < lo_thr * n && down_hold == 0) begin
         if (cur_level > lo) begin
            cnt = ring_fill < 30 ? ring_fill : 30;
            hits = 0;
            for (int i = 0; i < cnt; i++)
               if (longint'(recent_rate(i)) < lo_thr) hits++;
            if (hits > cnt * 6 / 10) begin
               step_to(cur_level - 1);
               down_hold = DOWN_HOLD;
               up_hold = UP_HOLD;
            end
         end
      end else if (sum > hi_thr * n && up_hold == 0) begin
         if (cur_level < hi) begin
            cnt = ring_fill < 60 ? ring_fill : 60;
            hits = 0;
            for (int i = 0; i < cnt; i++)
               if (2 * longint'(recent_rate(i)) > up2) hits++;
            if (hits > cnt * 8 / 10) begin
               step_to(cur_level + 1);
               up_hold = UP_HOLD;
            end
         end
      end
   endfunction

   function automatic void record_frame(longint unsigned dt, logic [RATE_W-1:0] rate);
      longint sum;
      longint unsigned t;
      sum = 0;
      if (!gov_enable || dt == 0) return;
      rate_ring[ring_wr] = rate;
      ring_wr = (ring_wr + 1) % HIST_DEPTH;
      if (ring_fill < HIST_DEPTH) ring_fill++;
      for (int i = 0; i < ring_fill; i++) sum += rate_ring[i];
      stored_mean = RATE_W'(sum / ring_fill);
      t = eval_timer + dt;
      eval_timer = t > 64'hFFFFFF ? 64'hFFFFFF : t;
      up_hold = up_hold > dt ? up_hold - dt : 0;
      down_hold = down_hold > dt ? down_hold - dt : 0;
      if (eval_timer >= gov_interval) begin
         eval_timer = 0;
         evaluate_level(sum);
      end
      // Emergency downgrade on a single slow frame.
      if (rate < gov_emerg && down_hold == 0 && cur_level > cap_level(gov_lowest)) begin
         step_to(cur_level - 1);
         down_hold = DOWN_HOLD;
         up_hold = UP_HOLD;
      end
   endfunction

   function automatic void restart_history(logic [LVL_W-1:0] req_level);
      int unsigned lv, lo, hi;
      lv = req_level;
      lo = cap_level(gov_lowest);
      hi = cap_level(gov_highest);
      if (lv < lo) lv = lo;
      if (lv > hi) lv = hi;
      step_to(lv);
      foreach (rate_ring[i]) rate_ring[i] = '0;
      ring_wr = 0;
      ring_fill = 0;
      eval_timer = 0;
      up_hold = 0;
      down_hold = 0;
   endfunction

   function automatic governor_result_type predict_governor(logic cmd,
                                                            logic [REQ_DW-1:0] d);
      governor_result_type r;
      r.prior_level = cur_level;
      stepped = 0;
      if (cmd) restart_history(d[36:34]);
      else record_frame(d[19:0], d[33:20]);
      r.level = cur_level;
      r.changed = stepped;
      r.mean_rate = stored_mean;
      r.adjustment_count = level_changes;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      governor_result_type got, want;
      if (reset) begin
         gov_enable = 1;
         gov_target = 960;
         gov_hyst = 80;
         gov_emerg = 480;
         gov_interval = 1000000;
         gov_lowest = 0;
         gov_highest = 4;
         foreach (rate_ring[i]) rate_ring[i] = '0;
         ring_wr = 0;
         ring_fill = 0;
         eval_timer = 0;
         up_hold = 0;
         down_hold = 0;
         cur_level = 4;
         stored_mean = 960;
         level_changes = 0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:   gov_enable = csr_wdata[0];
               CSR_TARGET:   gov_target = csr_wdata[RATE_W-1:0];
               CSR_HYST:     gov_hyst = csr_wdata[RATE_W-1:0];
               CSR_EMERG:    gov_emerg = csr_wdata[RATE_W-1:0];
               CSR_INTERVAL: gov_interval = csr_wdata;
               CSR_LOWEST:   gov_lowest = csr_wdata[LVL_W-1:0];
               CSR_HIGHEST:  gov_highest = csr_wdata[LVL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_governor(req_tuser, req_tdata));
         // Compare each result beat against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(governor_result_type)-1:0];
            if (expected_results.size() == 0) begin
               $error("result beat with no prediction pending: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, got.level);
                  fail_count++;
               end
               if (got.prior_level !== want.prior_level) begin
                  $error("prior_level: expected %0d, got %0d",
                         want.prior_level, got.prior_level);
                  fail_count++;
               end
               if (got.changed !== want.changed) begin
                  $error("changed: expected %0d, got %0d", want.changed, got.changed);
                  fail_count++;
               end
               if (got.mean_rate !== want.mean_rate) begin
                  $error("mean_rate: expected %0d, got %0d", want.mean_rate, got.mean_rate);
                  fail_count++;
               end
               if (got.adjustment_count !== want.adjustment_count) begin
                  $error("adjustment_count: expected %0d, got %0d",
                         want.adjustment_count, got.adjustment_count);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

### tb/frame_rate_quality_governor_test.sv
// Top of the frame rate quality governor testbench: clock, reset, stimulus,
// settings phases and verdict. Depends on frqg_pkg, the block and its checker.
`timescale 1ns / 1ps

module frame_rate_quality_governor_test;
   import frqg_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic                req_tuser = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic                csr_we = 0;
   logic [CSR_AW-1:0]   csr_index = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;
   int                  fail_count, pending_count;
   int                  cycle_count = 0;
   bit                  long_hold = 0;

   always #5 clock = ~clock;

   frame_rate_quality_governor u_dut (.*);

   frame_rate_quality_governor_checker u_checker (.*);

   // Hard limit on the run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls per beat, plus one long hold-off when asked.
   initial begin : rsp_side
      int gap;
      forever begin
         if (long_hold) begin
            @(posedge clock) rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            long_hold = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            @(posedge clock) rsp_tready <= 0;
            repeat (gap - 1) @(posedge clock);
         end
         @(posedge clock) rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         rsp_tready <= 0;
      end
   end

   // Valid stays high after an accepted beat; it drops only before an idle gap,
   // so back-to-back beats change the data without touching valid.
   task automatic send_beat(logic cmd, logic [19:0] dt, logic [13:0] rate,
                            logic [2:0] lvl, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {3'b000, lvl, rate, dt};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_setting(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Stops sending, waits until every prediction has been answered, then past
   // the latency.
   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic frame_burst(int count, int rate_lo, int rate_hi, bit quick);
      for (int i = 0; i < count; i++)
         send_beat(CMD_FRAME,
                   quick ? 20'($urandom_range(1, 400000)) : 20'($urandom_range(1, 40000)),
                   14'($urandom_range(rate_lo, rate_hi)), 3'($urandom_range(0, 7)),
                   $urandom_range(0, 3) == 0);
   endtask

   task automatic apply_settings(int en, int tgt, int hy, int em, int iv, int lo, int hi);
      write_setting(CSR_ENABLE, CSR_DW'(en));
      write_setting(CSR_TARGET, CSR_DW'(tgt));
      write_setting(CSR_HYST, CSR_DW'(hy));
      write_setting(CSR_EMERG, CSR_DW'(em));
      write_setting(CSR_INTERVAL, CSR_DW'(iv));
      write_setting(CSR_LOWEST, CSR_DW'(lo));
      write_setting(CSR_HIGHEST, CSR_DW'(hi));
   endtask

   initial begin : stimulus
      int kind;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, both commands, zero frame time, emergencies.
      send_beat(CMD_FRAME, 20'd0, 14'h3FFF, 3'd7, 1'b0);
      send_beat(CMD_FRAME, 20'd1000000, 14'h3FFF, 3'd0, 1'b0);
      send_beat(CMD_FRAME, 20'hFFFFF, 14'd0, 3'd7, 1'b0);
      send_beat(CMD_FRAME, 20'd1, 14'd100, 3'd0, 1'b0);
      send_beat(CMD_RESET, 20'hFFFFF, 14'h3FFF, 3'd7, 1'b0);
      send_beat(CMD_RESET, 20'd0, 14'd0, 3'd0, 1'b0);
      send_beat(CMD_RESET, 20'd0, 14'd0, 3'd3, 1'b0);
      frame_burst(12, 0, 300, 1);
      send_beat(CMD_RESET, 20'd0, 14'd0, 3'd4, 1'b0);
      frame_burst(8, 16000, 16383, 1);
      drain();

      // Disabled block; a reset still acts. Lowest above highest, levels above four.
      apply_settings(0, 960, 80, 480, 1000000, 6, 2);
      frame_burst(4, 0, 16383, 1);
      send_beat(CMD_RESET, 20'd0, 14'd0, 3'd7, 1'b0);
      send_beat(CMD_RESET, 20'd0, 14'd0, 3'd0, 1'b0);
      drain();

      // Random phases through several settings, extremes among them.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(1, 960, 80, 480, 0, 0, 7);
            1: apply_settings(1, 16383, 16383, 16383, 24'hFFFFFF, 5, 7);
            2: apply_settings(1, 0, 0, 0, 100000, 0, 4);
            3: apply_settings(1, 800, 40, 300, 200000, 1, 3);
            4: apply_settings(1, $urandom_range(0, 16383), $urandom_range(0, 2000),
                              $urandom_range(0, 16383), $urandom_range(0, 10000000),
                              $urandom_range(0, 7), $urandom_range(0, 7));
            default: apply_settings(1, 960, 80, 480, 1000000, 0, 4);
         endcase
         if (phase == 3) long_hold = 1;
         for (int i = 0; i < 80; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
               send_beat(CMD_RESET, 20'($urandom), 14'($urandom), 3'($urandom), 1'b0);
            else if (kind == 1)
               send_beat(CMD_FRAME, 20'd0, 14'($urandom), 3'($urandom), 1'b0);
            else if (kind < 9) frame_burst(1, 0, 700, 1);
            else if (kind < 16) frame_burst(1, 900, 16383, 1);
            else frame_burst(1, 0, 16383, $urandom_range(0, 1));
         end
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### frame_rate_quality_governor.f
hw/rtl/frqg_pkg.sv
hw/rtl/frqg_ctrl.sv
hw/rtl/frqg_dp.sv
hw/rtl/frame_rate_quality_governor.sv
tb/frame_rate_quality_governor_checker.sv
tb/frame_rate_quality_governor_test.sv
